FILE: sv/ordered_key_value_table_core_assert.svh
// ----------------------------------------------------------------------------
// ordered key/value table assertion macros
// shared concurrent assertion forms, clocked on clk
// ----------------------------------------------------------------------------
`ifndef ORDERED_KEY_VALUE_TABLE_CORE_ASSERT_SVH
`define ORDERED_KEY_VALUE_TABLE_CORE_ASSERT_SVH

// checked only outside reset
`define OKVT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define OKVT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/okvt_pkg.sv
// ----------------------------------------------------------------------------
// okvt_pkg
// constants, codes and cell control type for the ordered key/value table
// ----------------------------------------------------------------------------
package okvt_pkg;

  localparam int DEPTH      = 16;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int COUNT_BITS = $clog2(DEPTH + 1);
  localparam int POS_BITS   = 4;
  localparam int KIND_BITS  = 3;
  localparam int STAT_BITS  = 2;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_INSERT    = 3'd0,
    KIND_UPDATE    = 3'd1,
    KIND_UPSERT    = 3'd2,
    KIND_ERASE     = 3'd3,
    KIND_LOOKUP    = 3'd4,
    KIND_READ_POS  = 3'd5
  } okvt_kind_t;

  typedef enum logic [STAT_BITS-1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_REFUSED = 2'd1,
    STATUS_FULL    = 2'd2,
    STATUS_RANGE   = 2'd3
  } okvt_status_t;

  // per-cell write controls from the table control
  typedef struct packed {
    logic wr_key;
    logic wr_value;
    logic shift;
  } okvt_cell_ctl_t;

endpackage

FILE: sv/ordered_key_value_table_core.sv
// ----------------------------------------------------------------------------
// ordered_key_value_table_core
// insertion-ordered table of unique keys built as a chain of entry cells
// ----------------------------------------------------------------------------
// a transaction's result is registered and shows in the cycle after it is accepted
// throughput: one transaction per cycle unless the held output stalls the input;
//   all cells compare in parallel and an erase closes the gap with a one-step shift
//   along the cell chain; an output register parts the two sides; input stalls only while it is held
// reset clears the entry count and the output valid; entry storage is not
//   cleared and needs no clearing pass
// ----------------------------------------------------------------------------
`include "ordered_key_value_table_core_assert.svh"

module ordered_key_value_table_core
  import okvt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [KIND_BITS-1:0]  kind,
  input  logic [KEY_BITS-1:0]   req_key,
  input  logic [VALUE_BITS-1:0] req_value,
  input  logic [POS_BITS-1:0]   position,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STAT_BITS-1:0]  status,
  output logic [KEY_BITS-1:0]   found_key,
  output logic [VALUE_BITS-1:0] found_value,
  output logic [COUNT_BITS-1:0] entry_count
);

  logic [COUNT_BITS-1:0] held_count;
  logic [COUNT_BITS-1:0] held_count_next;
  logic [COUNT_BITS-1:0] count_step;

  logic                  accept;
  logic [DEPTH-1:0]      match;
  logic [DEPTH-1:0]      occupied;
  logic [DEPTH-1:0]      after_hit;
  logic                  hit;
  logic                  full;
  logic                  pos_ok;
  logic [VALUE_BITS-1:0] hit_value;
  logic                  append_go;
  logic                  update_go;
  logic                  erase_go;
  okvt_status_t          status_next;
  logic [KEY_BITS-1:0]   fkey_next;
  logic [VALUE_BITS-1:0] fval_next;

  logic [KEY_BITS-1:0]   cell_key   [DEPTH];
  logic [VALUE_BITS-1:0] cell_value [DEPTH];
  okvt_cell_ctl_t        cell_ctl   [DEPTH];

  assign accept   = in_valid && !in_stall;
  assign in_stall = out_valid && out_stall;

  // cell chain
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [KEY_BITS-1:0]   nkey;
    logic [VALUE_BITS-1:0] nvalue;

    if (g == DEPTH - 1) begin : g_last
      assign nkey   = '0;
      assign nvalue = '0;
    end else begin : g_mid
      assign nkey   = cell_key[g+1];
      assign nvalue = cell_value[g+1];
    end

    assign occupied[g] = COUNT_BITS'(g) < held_count;

    assign cell_ctl[g].wr_key   = append_go && (COUNT_BITS'(g) == held_count);
    assign cell_ctl[g].wr_value = (append_go && (COUNT_BITS'(g) == held_count)) ||
                                  (update_go && match[g]);
    assign cell_ctl[g].shift    = erase_go && after_hit[g];

    okvt_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[g]),
      .occupied   (occupied[g]),
      .req_key    (req_key),
      .req_value  (req_value),
      .next_key   (nkey),
      .next_value (nvalue),
      .key        (cell_key[g]),
      .value      (cell_value[g]),
      .match      (match[g])
    );
  end

  // at most one cell matches, so an or over the masked values selects it
  always_comb begin
    hit_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_value = hit_value | (cell_value[i] & {VALUE_BITS{match[i]}});
    end
  end

  // cells at or behind the matching cell
  always_comb begin
    after_hit[0] = match[0];
    for (int i = 1; i < DEPTH; i++) begin
      after_hit[i] = after_hit[i-1] | match[i];
    end
  end

  assign hit    = |match;
  assign full   = held_count == COUNT_BITS'(DEPTH);
  assign pos_ok = COUNT_BITS'(position) < held_count;

  always_comb begin
    append_go       = 1'b0;
    update_go       = 1'b0;
    erase_go        = 1'b0;
    status_next     = STATUS_REFUSED;
    fkey_next       = req_key;
    fval_next       = '0;
    held_count_next = held_count;
    unique case (kind)
      KIND_INSERT: begin
        if (!hit) begin
          if (full) begin
            status_next = STATUS_FULL;
          end else begin
            append_go   = 1'b1;
            status_next = STATUS_DONE;
          end
        end
      end
      KIND_UPSERT: begin
        if (hit) begin
          update_go   = 1'b1;
          status_next = STATUS_DONE;
        end else if (full) begin
          status_next = STATUS_FULL;
        end else begin
          append_go   = 1'b1;
          status_next = STATUS_DONE;
        end
      end
      KIND_UPDATE: begin
        if (hit) begin
          update_go   = 1'b1;
          status_next = STATUS_DONE;
        end
      end
      KIND_ERASE: begin
        if (hit) begin
          erase_go    = 1'b1;
          status_next = STATUS_DONE;
        end
      end
      KIND_LOOKUP: begin
        if (hit) begin
          fval_next   = hit_value;
          status_next = STATUS_DONE;
        end
      end
      KIND_READ_POS: begin
        if (pos_ok) begin
          fkey_next   = cell_key[position];
          fval_next   = cell_value[position];
          status_next = STATUS_DONE;
        end else begin
          status_next = STATUS_RANGE;
        end
      end
      default: begin
        status_next = STATUS_REFUSED;
      end
    endcase
    if (!accept) begin
      append_go = 1'b0;
      update_go = 1'b0;
      erase_go  = 1'b0;
    end
    if (append_go) begin
      held_count_next = held_count + COUNT_BITS'(1);
    end else if (erase_go) begin
      held_count_next = held_count - COUNT_BITS'(1);
    end
  end

  // change in entry count plus one, so steps of -1, 0 and +1 land in 0..2
  assign count_step = held_count_next - held_count + COUNT_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      held_count <= held_count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= status_next;
      found_key   <= fkey_next;
      found_value <= fval_next;
      entry_count <= held_count_next;
    end
  end

  `OKVT_ASSERT(a_unique_match, $onehot0(match), "more than one cell holds the request key")
  `OKVT_ASSERT(a_count_bound, held_count <= COUNT_BITS'(DEPTH), "entry count above depth")
  `OKVT_ASSERT(a_result_follows, accept |=> out_valid, "accepted transaction gave no result")
  `OKVT_ASSERT(a_count_step, count_step <= COUNT_BITS'(2), "entry count moved by more than one")
  `OKVT_ASSERT_ALWAYS(a_reset_clears, rst |=> !out_valid && (held_count == '0), "reset left state")

endmodule

FILE: sv/okvt_cell.sv
// ----------------------------------------------------------------------------
// okvt_cell
// one table entry: holds a key and value, compares against the request key
// and can take its upper neighbor's entry when it or an earlier entry is erased
// ----------------------------------------------------------------------------
module okvt_cell
  import okvt_pkg::*;
(
  input  logic                  clk,
  input  okvt_cell_ctl_t        ctl,
  input  logic                  occupied,
  input  logic [KEY_BITS-1:0]   req_key,
  input  logic [VALUE_BITS-1:0] req_value,
  input  logic [KEY_BITS-1:0]   next_key,
  input  logic [VALUE_BITS-1:0] next_value,
  output logic [KEY_BITS-1:0]   key,
  output logic [VALUE_BITS-1:0] value,
  output logic                  match
);

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      key   <= next_key;
      value <= next_value;
    end else begin
      if (ctl.wr_key) begin
        key <= req_key;
      end
      if (ctl.wr_value) begin
        value <= req_value;
      end
    end
  end

  assign match = occupied && (key == req_key);

endmodule
